/* rtl/core/segi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segi_pkg: shared types and helpers for the segment intersection block
// Coordinate width, derived widths, queue entry type and the divide step.
// ----------------------------------------------------------------------------
package segi_pkg;

  localparam int CB    = 16;          // coordinate width
  localparam int DLW   = CB + 1;      // difference width (signed)
  localparam int PW    = 2 * CB + 2;  // product width (signed)
  localparam int SW    = 2 * CB + 3;  // cross-product sum width (signed)
  localparam int DW    = 2 * CB + 2;  // normalized numerator / denominator width
  localparam int RW    = 2 * CB + 3;  // divider remainder width
  localparam int MW    = CB + 2;      // magnitude and quotient width
  localparam int NSTEP = CB + 2;      // divider steps, one multiplier bit each
  localparam int QDEPTH = 2;          // queue between front and back

  // One classified item as it travels from the front to the back
  typedef struct packed {
    logic                  hit;
    logic [DW-1:0]         num;
    logic [DW-1:0]         den;
    logic signed [CB-1:0]  base_x;
    logic signed [CB-1:0]  base_y;
    logic signed [DLW-1:0] dx;
    logic signed [DLW-1:0] dy;
  } segi_item_t;

  // Remainder and quotient of one divider lane
  typedef struct packed {
    logic [RW-1:0] r;
    logic [MW-1:0] q;
  } segi_rq_t;

  // One step of the shift-and-add divide: floor(num*mag/den), one bit of mag
  function automatic segi_rq_t segi_div_step(segi_rq_t cur, logic mbit,
                                             logic [DW-1:0] num, logic [DW-1:0] den);
    segi_rq_t      res;
    logic [RW-1:0] den_x;
    logic [RW-1:0] num_x;
    den_x = RW'(den);
    num_x = RW'(num);
    res.r = {cur.r[RW-2:0], 1'b0};
    res.q = {cur.q[MW-2:0], 1'b0};
    if (res.r >= den_x) begin
      res.r = res.r - den_x;
      res.q = res.q + MW'(1);
    end
    if (mbit) begin
      res.r = res.r + num_x;
      if (res.r >= den_x) begin
        res.r = res.r - den_x;
        res.q = res.q + MW'(1);
      end
    end
    return res;
  endfunction

endpackage

/* rtl/core/segment_intersection_point.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection_point: exact intersection of two integer segments
// Front classifies the pair, a two-entry queue decouples, back divides.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle; busy stays low as the back drains the queue
// every cycle.
// Path: 3 front stages, the queue entry, CB+3 divider stages, 1 output register.
// The receiver cannot stall; each result shows for one cycle with out_valid.
// Reset: synchronous active-low rst_n empties all stages and the queue.
module segment_intersection_point (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [segi_pkg::CB-1:0] in_a_x1,
  input  logic signed [segi_pkg::CB-1:0] in_a_y1,
  input  logic signed [segi_pkg::CB-1:0] in_a_x2,
  input  logic signed [segi_pkg::CB-1:0] in_a_y2,
  input  logic signed [segi_pkg::CB-1:0] in_b_x1,
  input  logic signed [segi_pkg::CB-1:0] in_b_y1,
  input  logic signed [segi_pkg::CB-1:0] in_b_x2,
  input  logic signed [segi_pkg::CB-1:0] in_b_y2,
  output logic                           out_valid,
  output logic                           out_hit,
  output logic signed [segi_pkg::CB-1:0] out_cross_x,
  output logic signed [segi_pkg::CB-1:0] out_cross_y
);
  import segi_pkg::*;

  logic       acc, f_valid, q_ne, q_full;
  segi_item_t f_item, q_head;

  assign acc  = start && !busy;
  assign busy = q_full;

  // classification front
  segi_front u_front (
    .clk, .rst_n, .acc,
    .a_x1(in_a_x1), .a_y1(in_a_y1), .a_x2(in_a_x2), .a_y2(in_a_y2),
    .b_x1(in_b_x1), .b_y1(in_b_y1), .b_x2(in_b_x2), .b_y2(in_b_y2),
    .item_valid(f_valid), .item(f_item)
  );

  // decoupling queue
  segi_queue u_queue (
    .clk, .rst_n,
    .push(f_valid), .push_item(f_item),
    .pop(1'b1), .not_empty(q_ne), .full(q_full), .head(q_head)
  );

  // divide back end
  segi_back u_back (
    .clk, .rst_n,
    .in_vld(q_ne), .in_item(q_head),
    .res_valid(out_valid), .res_hit(out_hit),
    .res_x(out_cross_x), .res_y(out_cross_y)
  );

`ifndef SYNTH
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_cross_x == '0 && out_cross_y == '0)
    else $error("miss beat with nonzero point");
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("queue filled although back drains every cycle");
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");
`endif

endmodule

/* rtl/core/segi_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segi_front: takes a segment pair and classifies it
// Three stages: differences, products, normalized cross sums and hit test.
// ----------------------------------------------------------------------------
module segi_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         acc,
  input  logic signed [segi_pkg::CB-1:0] a_x1,
  input  logic signed [segi_pkg::CB-1:0] a_y1,
  input  logic signed [segi_pkg::CB-1:0] a_x2,
  input  logic signed [segi_pkg::CB-1:0] a_y2,
  input  logic signed [segi_pkg::CB-1:0] b_x1,
  input  logic signed [segi_pkg::CB-1:0] b_y1,
  input  logic signed [segi_pkg::CB-1:0] b_x2,
  input  logic signed [segi_pkg::CB-1:0] b_y2,
  output logic                         item_valid,
  output segi_pkg::segi_item_t         item
);
  import segi_pkg::*;

  // stage 1: direction and offset vectors
  logic                  v1_r;
  logic signed [DLW-1:0] dax_r, day_r, dbx_r, dby_r, ex_r, ey_r;
  logic signed [CB-1:0]  bx1_r, by1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    dax_r <= DLW'(a_x2) - DLW'(a_x1);
    day_r <= DLW'(a_y2) - DLW'(a_y1);
    dbx_r <= DLW'(b_x2) - DLW'(b_x1);
    dby_r <= DLW'(b_y2) - DLW'(b_y1);
    ex_r  <= DLW'(a_x1) - DLW'(b_x1);
    ey_r  <= DLW'(a_y1) - DLW'(b_y1);
    bx1_r <= a_x1;
    by1_r <= a_y1;
  end

  // stage 2: the six cross products
  logic                  v2_r;
  logic signed [PW-1:0]  p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  logic signed [CB-1:0]  bx2_r, by2_r;
  logic signed [DLW-1:0] dx2_r, dy2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    p0_r  <= PW'(dax_r) * PW'(dby_r);
    p1_r  <= PW'(dbx_r) * PW'(day_r);
    p2_r  <= PW'(dax_r) * PW'(ey_r);
    p3_r  <= PW'(day_r) * PW'(ex_r);
    p4_r  <= PW'(dbx_r) * PW'(ey_r);
    p5_r  <= PW'(dby_r) * PW'(ex_r);
    bx2_r <= bx1_r;
    by2_r <= by1_r;
    dx2_r <= dax_r;
    dy2_r <= day_r;
  end

  // stage 3: sign-normalize den, sn, tn and test both parameters
  logic signed [SW-1:0] den, sn, tn, den_n, sn_n, tn_n;
  logic                 hit;

  always_comb begin
    den = SW'(p0_r) - SW'(p1_r);
    sn  = SW'(p2_r) - SW'(p3_r);
    tn  = SW'(p4_r) - SW'(p5_r);
    if (den < 0) begin
      den_n = -den;
      sn_n  = -sn;
      tn_n  = -tn;
    end else begin
      den_n = den;
      sn_n  = sn;
      tn_n  = tn;
    end
    hit = (den_n != '0) && (sn_n >= 0) && (sn_n <= den_n) && (tn_n >= 0) && (tn_n <= den_n);
  end

  logic       v3_r;
  segi_item_t item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    item_r.hit    <= hit;
    item_r.num    <= tn_n[DW-1:0];
    item_r.den    <= den_n[DW-1:0];
    item_r.base_x <= bx2_r;
    item_r.base_y <= by2_r;
    item_r.dx     <= dx2_r;
    item_r.dy     <= dy2_r;
  end

  assign item_valid = v3_r;
  assign item       = item_r;

endmodule

/* rtl/core/segi_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segi_queue: short queue between the front and the back
// Two entries; the back pops whenever an entry is present.
// ----------------------------------------------------------------------------
module segi_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  segi_pkg::segi_item_t push_item,
  input  logic                 pop,
  output logic                 not_empty,
  output logic                 full,
  output segi_pkg::segi_item_t head
);
  import segi_pkg::*;

  segi_item_t mem_r [QDEPTH];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_pop;

  assign not_empty = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'(QDEPTH));
  assign do_pop    = pop && not_empty;
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) cnt_nxt = cnt_r + 2'd1;
    else if (!push && do_pop) cnt_nxt = cnt_r - 2'd1;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

endmodule

/* rtl/core/segi_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segi_back: computes the intersection point
// Pipelined shift-and-add divider per coordinate, then the truncation fix.
// ----------------------------------------------------------------------------
module segi_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_vld,
  input  segi_pkg::segi_item_t           in_item,
  output logic                           res_valid,
  output logic                           res_hit,
  output logic signed [segi_pkg::CB-1:0] res_x,
  output logic signed [segi_pkg::CB-1:0] res_y
);
  import segi_pkg::*;

  typedef struct packed {
    logic                 hit;
    logic [DW-1:0]        num;
    logic [DW-1:0]        den;
    logic signed [CB-1:0] base_x;
    logic signed [CB-1:0] base_y;
    logic                 neg_x;
    logic                 neg_y;
    logic [MW-1:0]        mag_x;
    logic [MW-1:0]        mag_y;
    segi_rq_t             rq_x;
    segi_rq_t             rq_y;
  } segi_stage_t;

  logic        vld_r [NSTEP+1];
  segi_stage_t stg_r [NSTEP+1];

  // stage 0: load item, take magnitudes of the directions
  logic [MW-1:0] mag_x0, mag_y0;
  always_comb begin
    mag_x0 = in_item.dx[DLW-1] ? MW'(-in_item.dx) : MW'(in_item.dx);
    mag_y0 = in_item.dy[DLW-1] ? MW'(-in_item.dy) : MW'(in_item.dy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    stg_r[0].hit    <= in_item.hit;
    stg_r[0].num    <= in_item.num;
    stg_r[0].den    <= in_item.den;
    stg_r[0].base_x <= in_item.base_x;
    stg_r[0].base_y <= in_item.base_y;
    stg_r[0].neg_x  <= in_item.dx[DLW-1];
    stg_r[0].neg_y  <= in_item.dy[DLW-1];
    stg_r[0].mag_x  <= mag_x0;
    stg_r[0].mag_y  <= mag_y0;
    stg_r[0].rq_x   <= '0;
    stg_r[0].rq_y   <= '0;
  end

  // divider stages, most significant multiplier bit first
  for (genvar j = 0; j < NSTEP; j++) begin : g_step
    segi_stage_t nxt;
    always_comb begin
      nxt      = stg_r[j];
      nxt.rq_x = segi_div_step(stg_r[j].rq_x, stg_r[j].mag_x[NSTEP-1-j],
                               stg_r[j].num, stg_r[j].den);
      nxt.rq_y = segi_div_step(stg_r[j].rq_y, stg_r[j].mag_y[NSTEP-1-j],
                               stg_r[j].num, stg_r[j].den);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else begin
        vld_r[j+1] <= vld_r[j];
      end
    end

    always_ff @(posedge clk) begin
      stg_r[j+1] <= nxt;
    end
  end

  // signed quotient, then truncate toward zero
  logic signed [MW:0] val_x, val_y;
  logic               rnz_x, rnz_y;
  segi_stage_t        fin;

  always_comb begin
    fin   = stg_r[NSTEP];
    rnz_x = (fin.rq_x.r != '0);
    rnz_y = (fin.rq_y.r != '0);
    if (fin.neg_x) val_x = (MW+1)'(fin.base_x) - (MW+1)'(fin.rq_x.q) - (MW+1)'(rnz_x);
    else           val_x = (MW+1)'(fin.base_x) + (MW+1)'(fin.rq_x.q);
    if (val_x < 0 && rnz_x) val_x = val_x + (MW+1)'(1);
    if (fin.neg_y) val_y = (MW+1)'(fin.base_y) - (MW+1)'(fin.rq_y.q) - (MW+1)'(rnz_y);
    else           val_y = (MW+1)'(fin.base_y) + (MW+1)'(fin.rq_y.q);
    if (val_y < 0 && rnz_y) val_y = val_y + (MW+1)'(1);
  end

  // result register
  logic                 res_valid_r, res_hit_r;
  logic signed [CB-1:0] res_x_r, res_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= vld_r[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    res_hit_r <= fin.hit;
    res_x_r   <= fin.hit ? val_x[CB-1:0] : '0;
    res_y_r   <= fin.hit ? val_y[CB-1:0] : '0;
  end

  assign res_valid = res_valid_r;
  assign res_hit   = res_hit_r;
  assign res_x     = res_x_r;
  assign res_y     = res_y_r;

endmodule

/* tb/segi_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segi_checker: predicts and checks segment intersection results
// Watches accepted input beats, computes the expected hit and point with
// exact integer math, and compares each output beat in order.
// ----------------------------------------------------------------------------
module segi_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic signed [segi_pkg::CB-1:0] in_a_x1,
  input  logic signed [segi_pkg::CB-1:0] in_a_y1,
  input  logic signed [segi_pkg::CB-1:0] in_a_x2,
  input  logic signed [segi_pkg::CB-1:0] in_a_y2,
  input  logic signed [segi_pkg::CB-1:0] in_b_x1,
  input  logic signed [segi_pkg::CB-1:0] in_b_y1,
  input  logic signed [segi_pkg::CB-1:0] in_b_x2,
  input  logic signed [segi_pkg::CB-1:0] in_b_y2,
  input  logic                           out_valid,
  input  logic                           out_hit,
  input  logic signed [segi_pkg::CB-1:0] out_cross_x,
  input  logic signed [segi_pkg::CB-1:0] out_cross_y,
  output int                             fail_count,
  output int                             pending
);
  import segi_pkg::*;

  typedef struct packed {
    logic                 hit;
    logic signed [CB-1:0] cx;
    logic signed [CB-1:0] cy;
  } point_t;

  point_t expected_points[$];

  // base + num*delta/den, truncated toward zero (0 <= num <= den, den > 0)
  function automatic logic signed [CB-1:0] lerp_toward_zero(longint base, longint num,
                                                            longint den, longint delta);
    longint prod;
    longint q;
    longint val;
    prod = num * delta;            // |prod| < 2^51, exact
    q = prod / den;                // truncates toward zero
    if (prod < 0 && q * den != prod) q = q - 1;   // floor
    val = base + q;
    if (val < 0 && q * den != prod) val = val + 1;
    return CB'(val);
  endfunction

  function automatic point_t intersect_pair(longint ax1, longint ay1, longint ax2,
                                            longint ay2, longint bx1, longint by1,
                                            longint bx2, longint by2);
    point_t p;
    longint dax, day, dbx, dby, ex, ey, den, sn, tn;
    dax = ax2 - ax1; day = ay2 - ay1;
    dbx = bx2 - bx1; dby = by2 - by1;
    ex = ax1 - bx1;  ey = ay1 - by1;
    den = dax * dby - dbx * day;
    sn = dax * ey - day * ex;
    tn = dbx * ey - dby * ex;
    if (den < 0) begin
      den = -den; sn = -sn; tn = -tn;
    end
    p = '0;
    p.hit = den != 0 && sn >= 0 && sn <= den && tn >= 0 && tn <= den;
    if (p.hit) begin
      p.cx = lerp_toward_zero(ax1, tn, den, dax);
      p.cy = lerp_toward_zero(ay1, tn, den, day);
    end
    return p;
  endfunction

  assign pending = expected_points.size();

  // Predict on accepted input beats, compare on output beats
  always @(posedge clk) begin
    point_t e;
    if (rst_n && out_valid) begin
      if (expected_points.size() == 0) begin
        fail_count <= fail_count + 1;
        if (fail_count < 10)
          $display("unexpected result beat: hit=%0d x=%0d y=%0d",
                   out_hit, out_cross_x, out_cross_y);
      end else begin
        e = expected_points.pop_front();
        if (e.hit !== out_hit || e.cx !== out_cross_x || e.cy !== out_cross_y) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("result mismatch: exp hit=%0d x=%0d y=%0d, got hit=%0d x=%0d y=%0d",
                     e.hit, e.cx, e.cy, out_hit, out_cross_x, out_cross_y);
        end
      end
    end
    if (rst_n && start && !busy)
      expected_points.push_back(intersect_pair(in_a_x1, in_a_y1, in_a_x2, in_a_y2,
                                               in_b_x1, in_b_y1, in_b_x2, in_b_y2));
  end

  initial fail_count = 0;
endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the segment intersection block
// Directed corner pairs, then random pairs biased toward real crossings,
// with random gaps between beats; a checker module scores the results.
// ----------------------------------------------------------------------------
module tb;
  import segi_pkg::*;

  localparam int RANDOM_PAIRS = 1030;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [CB-1:0] ax1 = '0, ay1 = '0, ax2 = '0, ay2 = '0;
  logic signed [CB-1:0] bx1 = '0, by1 = '0, bx2 = '0, by2 = '0;
  logic out_valid, out_hit;
  logic signed [CB-1:0] out_cross_x, out_cross_y;
  int fail_count, pending;

  always #1 clk = ~clk;

  segment_intersection_point i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_a_x1(ax1), .in_a_y1(ay1), .in_a_x2(ax2), .in_a_y2(ay2),
    .in_b_x1(bx1), .in_b_y1(by1), .in_b_x2(bx2), .in_b_y2(by2),
    .out_valid(out_valid), .out_hit(out_hit),
    .out_cross_x(out_cross_x), .out_cross_y(out_cross_y)
  );

  segi_checker i_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_a_x1(ax1), .in_a_y1(ay1), .in_a_x2(ax2), .in_a_y2(ay2),
    .in_b_x1(bx1), .in_b_y1(by1), .in_b_x2(bx2), .in_b_y2(by2),
    .out_valid(out_valid), .out_hit(out_hit),
    .out_cross_x(out_cross_x), .out_cross_y(out_cross_y),
    .fail_count(fail_count), .pending(pending)
  );

  // Send one pair: random gap, then hold start until the beat is taken
  task automatic send_pair(int p0, int p1, int p2, int p3, int p4, int p5, int p6, int p7);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    ax1 <= CB'(p0); ay1 <= CB'(p1); ax2 <= CB'(p2); ay2 <= CB'(p3);
    bx1 <= CB'(p4); by1 <= CB'(p5); bx2 <= CB'(p6); by2 <= CB'(p7);
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic int any_coord();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // Random coordinate in the window [-span, span]; small windows give many crossings
  function automatic int near_coord(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  initial begin
    int span, mode;
    int c[8];
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: X crossing, endpoint touches, T junction, parallel, collinear,
    // degenerate, full-range diagonals, negative truncation
    send_pair(-10, -10, 10, 10, -10, 10, 10, -10);
    send_pair(0, 0, 10, 0, 10, 0, 10, 10);
    send_pair(0, 0, 10, 0, 0, 0, 0, 5);
    send_pair(0, 0, 10, 10, 10, 10, 20, 0);
    send_pair(0, 0, 10, 0, 5, 0, 5, 7);
    send_pair(0, 0, 10, 0, 0, 1, 10, 1);
    send_pair(0, 0, 10, 0, 5, 0, 15, 0);
    send_pair(3, 3, 3, 3, 0, 0, 6, 6);
    send_pair(3, 3, 3, 3, 3, 3, 3, 3);
    send_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    send_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767);
    send_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767);
    send_pair(-32768, -32768, -32768, 32767, -32768, 0, 32767, 0);
    send_pair(0, 0, -7, -3, -1, 0, -1, -5);
    send_pair(0, 0, 7, 3, 1, 0, 1, 5);
    send_pair(-1, -1, -4, -2, -2, 0, -3, -3);
    send_pair(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768);
    send_pair(-32768, 32767, 32767, -32768, 32767, 32767, -32768, -32768);
    send_pair(0, 0, 0, 0, 0, 0, 0, 0);
    send_pair(-1, -1, -1, -1, -1, -1, -1, -1);

    // Let everything drain before the random part
    start <= 1'b0;
    while (pending != 0) @(posedge clk);

    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      mode = $urandom_range(0, 9);
      span = (mode < 4) ? 16 : (mode < 8) ? 32767 : 0;
      for (int k = 0; k < 8; k++)
        c[k] = (mode >= 8) ? any_coord() : near_coord(span);
      if (mode == 9) begin
        c[6] = c[4] + (c[2] - c[0]) / 2;   // near-parallel/noise mix
        c[7] = c[5] + (c[3] - c[1]) / 2;
        c[6] = (c[6] > 32767) ? 32767 : (c[6] < -32768) ? -32768 : c[6];
        c[7] = (c[7] > 32767) ? 32767 : (c[7] < -32768) ? -32768 : c[7];
      end
      send_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #200000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

/* filelist.f */
rtl/core/segi_pkg.sv
rtl/core/segi_front.sv
rtl/core/segi_queue.sv
rtl/core/segi_back.sv
rtl/core/segment_intersection_point.sv
tb/segi_checker.sv
tb/tb.sv
